// File: rtl/msq_pkg.sv
// Package: shared constants, codes, types and helpers of the message slot queue manager.
package msq_pkg;

    localparam int SLOTS  = 64;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SLOT_W = 7;
    localparam int LEN_W  = 12;
    localparam int CNT_W  = 7;

    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_COMMIT  = 3'd1;
    localparam logic [2:0] REQ_TAKE    = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_CLEAN   = 3'd4;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_NOCFG   = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_BADLEN  = 3'd3;
    localparam logic [2:0] STAT_EMPTY   = 3'd4;
    localparam logic [2:0] STAT_BADSLOT = 3'd5;

    localparam logic [0:0] CFG_SLOT_COUNT = 1'd0;
    localparam logic [0:0] CFG_MAX_LEN    = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK2,
        S_CLEAN
    } state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_count;
        logic [LEN_W-1:0]  max_len;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0] free_head;
        logic [SLOT_W-1:0] queue_head;
    } stat_t;

    // slot number 1..SLOTS to store address
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] t;
        t = s - SLOT_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/msq_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface msq_req_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   req_type;
    logic [msq_pkg::SLOT_W-1:0]   slot;
    logic [msq_pkg::LEN_W-1:0]    length;
    logic                         lifo;

    modport source (output valid, output req_type, output slot, output length, output lifo,
                    input ready);
    modport sink (input valid, input req_type, input slot, input length, input lifo,
                  output ready);
endinterface

interface msq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [msq_pkg::SLOT_W-1:0]   slot_out;
    logic [msq_pkg::LEN_W-1:0]    length_out;
    logic [msq_pkg::CNT_W-1:0]    queued_count;

    modport source (output valid, output status, output slot_out, output length_out,
                    output queued_count, input ready);
    modport sink (input valid, input status, input slot_out, input length_out,
                  input queued_count, output ready);
endinterface

// File: rtl/msq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module msq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/msq_ctrl.sv
// Controller: request sequencer, chain head registers, clean sweep and result register.
module msq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    msq_req_if.sink                       req,
    msq_rsp_if.source                     rsp,
    input  msq_pkg::cfg_t                 cfg,
    output logic                          link_we,
    output logic [msq_pkg::ADDR_W-1:0]    link_waddr,
    output logic [msq_pkg::SLOT_W-1:0]    link_wdata,
    output logic                          link_re,
    output logic [msq_pkg::ADDR_W-1:0]    link_raddr,
    input  logic [msq_pkg::SLOT_W-1:0]    link_rdata,
    output logic                          len_we,
    output logic [msq_pkg::ADDR_W-1:0]    len_waddr,
    output logic [msq_pkg::LEN_W-1:0]     len_wdata,
    output logic                          len_re,
    output logic [msq_pkg::ADDR_W-1:0]    len_raddr,
    input  logic [msq_pkg::LEN_W-1:0]     len_rdata,
    output msq_pkg::stat_t                stat
);

    localparam int SW = msq_pkg::SLOT_W;
    localparam int LW = msq_pkg::LEN_W;
    localparam int CW = msq_pkg::CNT_W;

    msq_pkg::state_t state_reg, state_next;

    logic [2:0]    req_type_reg;
    logic [SW-1:0] slot_reg;
    logic [LW-1:0] len_reg;
    logic          lifo_reg;

    logic [SW-1:0] free_head_reg, free_head_next;
    logic [SW-1:0] qh_reg, qh_next;
    logic [SW-1:0] qt_reg, qt_next;
    logic [CW-1:0] wcnt_reg, wcnt_next;
    logic [SW-1:0] clean_cnt_reg, clean_cnt_next;
    logic [SW-1:0] clean_n_reg, clean_n_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [SW-1:0] out_slot_reg, out_slot_next;
    logic [LW-1:0] out_len_reg, out_len_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;

    logic          accept;
    logic          go;
    logic          emit;
    logic [2:0]    st;
    logic [SW-1:0] so;
    logic [LW-1:0] lo;
    logic [SW-1:0] n_act;
    logic [LW:0]   limit;
    logic          slot_ok;
    logic          cfg_off;

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == msq_pkg::S_IDLE);
    assign go      = !out_valid_reg || rsp.ready;

    assign n_act   = (cfg.slot_count > SW'(msq_pkg::SLOTS)) ? SW'(msq_pkg::SLOTS)
                                                            : cfg.slot_count;
    assign limit   = ({1'b0, cfg.max_len} + (LW+1)'(3)) & ~(LW+1)'(3);
    assign slot_ok = (slot_reg != '0) && (slot_reg <= n_act);
    assign cfg_off = (cfg.max_len == '0);

    // reads are issued at the accept edge, data is used in S_EXEC
    assign link_re    = accept;
    assign link_raddr = (req.req_type == msq_pkg::REQ_ALLOC) ? msq_pkg::slot_addr(free_head_reg)
                                                             : msq_pkg::slot_addr(qh_reg);
    assign len_re     = accept;
    assign len_raddr  = msq_pkg::slot_addr(qh_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            slot_reg     <= req.slot;
            len_reg      <= req.length;
            lifo_reg     <= req.lifo;
        end
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_len_reg    <= out_len_next;
        out_cnt_reg    <= out_cnt_next;
    end

    // reset starts a full clean sweep with the reset configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msq_pkg::S_CLEAN;
            free_head_reg <= SW'(msq_pkg::SLOTS);
            qh_reg        <= '0;
            qt_reg        <= '0;
            wcnt_reg      <= '0;
            clean_cnt_reg <= SW'(1);
            clean_n_reg   <= SW'(msq_pkg::SLOTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            qh_reg        <= qh_next;
            qt_reg        <= qt_next;
            wcnt_reg      <= wcnt_next;
            clean_cnt_reg <= clean_cnt_next;
            clean_n_reg   <= clean_n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        qh_next        = qh_reg;
        qt_next        = qt_reg;
        wcnt_next      = wcnt_reg;
        clean_cnt_next = clean_cnt_reg;
        clean_n_next   = clean_n_reg;
        link_we        = 1'b0;
        link_waddr     = msq_pkg::slot_addr(slot_reg);
        link_wdata     = '0;
        len_we         = 1'b0;
        len_waddr      = msq_pkg::slot_addr(slot_reg);
        len_wdata      = len_reg;
        emit           = 1'b0;
        st             = msq_pkg::STAT_OK;
        so             = '0;
        lo             = '0;

        case (state_reg)
            msq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = msq_pkg::S_EXEC;
                end
            end

            msq_pkg::S_EXEC:
            begin
                if (go)
                begin
                    emit       = 1'b1;
                    state_next = msq_pkg::S_IDLE;
                    case (req_type_reg)
                        msq_pkg::REQ_ALLOC:
                        begin
                            if (cfg_off)
                            begin
                                st = msq_pkg::STAT_NOCFG;
                            end
                            else if (free_head_reg == '0)
                            begin
                                st = msq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                so             = free_head_reg;
                                free_head_next = link_rdata;
                            end
                        end

                        msq_pkg::REQ_COMMIT:
                        begin
                            if (!slot_ok)
                            begin
                                st = msq_pkg::STAT_BADSLOT;
                            end
                            else if ({1'b0, len_reg} > limit)
                            begin
                                st             = msq_pkg::STAT_BADLEN;
                                link_we        = 1'b1;
                                link_wdata     = free_head_reg;
                                free_head_next = slot_reg;
                            end
                            else
                            begin
                                len_we = 1'b1;
                                if (len_reg == '0)
                                begin
                                    link_we        = 1'b1;
                                    link_wdata     = free_head_reg;
                                    free_head_next = slot_reg;
                                end
                                else if (lifo_reg)
                                begin
                                    link_we    = 1'b1;
                                    link_wdata = qh_reg;
                                    qh_next    = slot_reg;
                                    if (qt_reg == '0)
                                    begin
                                        qt_next = slot_reg;
                                    end
                                    if (wcnt_reg != '1)
                                    begin
                                        wcnt_next = wcnt_reg + CW'(1);
                                    end
                                end
                                else if (qt_reg != '0)
                                begin
                                    // tail link first, new slot link in S_LINK2
                                    link_we    = 1'b1;
                                    link_waddr = msq_pkg::slot_addr(qt_reg);
                                    link_wdata = slot_reg;
                                    emit       = 1'b0;
                                    state_next = msq_pkg::S_LINK2;
                                end
                                else
                                begin
                                    link_we    = 1'b1;
                                    link_wdata = '0;
                                    qt_next    = slot_reg;
                                    if (qh_reg == '0)
                                    begin
                                        qh_next = slot_reg;
                                    end
                                    if (wcnt_reg != '1)
                                    begin
                                        wcnt_next = wcnt_reg + CW'(1);
                                    end
                                end
                            end
                        end

                        msq_pkg::REQ_TAKE:
                        begin
                            if (cfg_off)
                            begin
                                st = msq_pkg::STAT_NOCFG;
                            end
                            else if (wcnt_reg == '0 || qh_reg == '0)
                            begin
                                st = msq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                so = qh_reg;
                                lo = len_rdata;
                                if (qt_reg == qh_reg)
                                begin
                                    qh_next = '0;
                                    qt_next = '0;
                                end
                                else
                                begin
                                    qh_next = link_rdata;
                                end
                                wcnt_next = wcnt_reg - CW'(1);
                            end
                        end

                        msq_pkg::REQ_RELEASE:
                        begin
                            if (!slot_ok)
                            begin
                                st = msq_pkg::STAT_BADSLOT;
                            end
                            else
                            begin
                                link_we        = 1'b1;
                                link_wdata     = free_head_reg;
                                free_head_next = slot_reg;
                            end
                        end

                        msq_pkg::REQ_CLEAN:
                        begin
                            free_head_next = '0;
                            qh_next        = '0;
                            qt_next        = '0;
                            wcnt_next      = '0;
                            if (!cfg_off)
                            begin
                                free_head_next = n_act;
                                if (n_act != '0)
                                begin
                                    clean_n_next   = n_act;
                                    clean_cnt_next = SW'(1);
                                    state_next     = msq_pkg::S_CLEAN;
                                end
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            msq_pkg::S_LINK2:
            begin
                if (go)
                begin
                    emit       = 1'b1;
                    state_next = msq_pkg::S_IDLE;
                    link_we    = 1'b1;
                    link_wdata = '0;
                    qt_next    = slot_reg;
                    if (qh_reg == '0)
                    begin
                        qh_next = slot_reg;
                    end
                    if (wcnt_reg != '1)
                    begin
                        wcnt_next = wcnt_reg + CW'(1);
                    end
                end
            end

            msq_pkg::S_CLEAN:
            begin
                // slot i links to slot i-1, one entry per cycle
                link_we    = 1'b1;
                link_waddr = msq_pkg::slot_addr(clean_cnt_reg);
                link_wdata = clean_cnt_reg - SW'(1);
                if (clean_cnt_reg == clean_n_reg)
                begin
                    state_next = msq_pkg::S_IDLE;
                end
                else
                begin
                    clean_cnt_next = clean_cnt_reg + SW'(1);
                end
            end

            default:
            begin
                state_next = msq_pkg::S_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_len_next    = out_len_reg;
        out_cnt_next    = out_cnt_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = st;
            out_slot_next   = so;
            out_len_next    = lo;
            out_cnt_next    = wcnt_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot_out     = out_slot_reg;
    assign rsp.length_out   = out_len_reg;
    assign rsp.queued_count = out_cnt_reg;

    assign stat.free_head  = free_head_reg;
    assign stat.queue_head = qh_reg;

endmodule

// File: rtl/message_slot_queue_manager.sv
// Top level: message slot queue manager with link and length stores and config registers.
// Each accepted request runs in S_EXEC, which waits while a prior result is held, then
// registers the result; a tail append to a non-empty queue passes through S_LINK2 first.
// Clean gives its result, then (if max_len is not 0) sweeps slots 1 to min(slot_count,64)
// of the link store, one slot per cycle; a new item is accepted only once the last is done.
// Reset: slot_count 64, max_len 64, empty queue; a 64-slot sweep rebuilds the free chain.
module message_slot_queue_manager (
    input  logic                        clk,
    input  logic                        rst_n,
    msq_req_if.sink                     req,
    msq_rsp_if.source                   rsp,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [msq_pkg::LEN_W-1:0]   cfg_data
);

    msq_pkg::cfg_t  cfg;
    msq_pkg::stat_t stat;

    logic [msq_pkg::SLOT_W-1:0] slot_count_reg;
    logic [msq_pkg::LEN_W-1:0]  max_len_reg;

    logic                          link_we;
    logic [msq_pkg::ADDR_W-1:0]    link_waddr;
    logic [msq_pkg::SLOT_W-1:0]    link_wdata;
    logic                          link_re;
    logic [msq_pkg::ADDR_W-1:0]    link_raddr;
    logic [msq_pkg::SLOT_W-1:0]    link_rdata;
    logic                          len_we;
    logic [msq_pkg::ADDR_W-1:0]    len_waddr;
    logic [msq_pkg::LEN_W-1:0]     len_wdata;
    logic                          len_re;
    logic [msq_pkg::ADDR_W-1:0]    len_raddr;
    logic [msq_pkg::LEN_W-1:0]     len_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= msq_pkg::SLOT_W'(64);
            max_len_reg    <= msq_pkg::LEN_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msq_pkg::CFG_SLOT_COUNT: slot_count_reg <= cfg_data[msq_pkg::SLOT_W-1:0];
                msq_pkg::CFG_MAX_LEN:    max_len_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.slot_count = slot_count_reg;
    assign cfg.max_len    = max_len_reg;

    msq_ram #(
        .WIDTH (msq_pkg::SLOT_W),
        .DEPTH (msq_pkg::SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    msq_ram #(
        .WIDTH (msq_pkg::LEN_W),
        .DEPTH (msq_pkg::SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    msq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_re    (link_re),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_re     (len_re),
        .len_raddr  (len_raddr),
        .len_rdata  (len_rdata),
        .stat       (stat)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("item accepted while previous item still in work");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> !$past(req.ready))
        else $error("result appeared without an item in work");

    a_slot_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.slot_out != '0 |-> rsp.status == msq_pkg::STAT_OK)
        else $error("slot handed out with a failure status");

    a_heads_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.free_head <= msq_pkg::SLOT_W'(msq_pkg::SLOTS)
        && stat.queue_head <= msq_pkg::SLOT_W'(msq_pkg::SLOTS))
        else $error("chain head outside the slot range");

endmodule
